FILE: design/spte_pkg.sv
// Package with the constants and types of the section page table engine.
`default_nettype none

package spte_pkg;

  // Section size is 2^SECTION_SHIFT bytes; the table holds one entry per section.
  localparam int SECTION_SHIFT = 20;
  localparam int ADDR_W        = 32;
  localparam int IDX_W         = ADDR_W - SECTION_SHIFT;
  localparam int DEPTH         = 1 << IDX_W;
  // Section count of a region: wide enough to hold DEPTH itself.
  localparam int COUNT_W       = ADDR_W + 1 - SECTION_SHIFT;
  localparam int ENTRY_W       = 32;

  localparam int OP_W          = 2;
  localparam int IN_FIELDS_W   = OP_W + 3 * ADDR_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = 2;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic tlb_invalidate;
    logic is_mapped;
  } result_t;

endpackage

`default_nettype wire

FILE: design/section_page_table_engine.sv
// Top level of the section page table engine: table memory, sequencer and output register.
`default_nettype none

// The block keeps a table of one-megabyte section descriptors in a single-port-write,
// one-read synchronous memory. After reset a clearing pass writes zero to all 4096
// entries, one per cycle, and the input is not ready until that pass ends. Items
// are handled one at a time. A query passes through a memory read, a compare and an
// output load. A map or unmap writes N entries, one per cycle on the memory write port,
// before its output load, where N is the region size rounded up to whole megabytes
// (1 to 4096); a zero size or an unused operation code goes straight to the output load.
// A result not taken holds the block in its final state until the output register frees.
module section_page_table_engine (
  input  wire  logic                              clk,
  input  wire  logic                              rst_n,
  input  wire  logic                              in_tvalid,
  output logic                                    in_tready,
  // Fields from bit 0: operation[1:0], address[31:0], region_bytes[31:0], attributes[31:0].
  input  wire  logic [spte_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                    out_tvalid,
  input  wire  logic                              out_tready,
  // Fields from bit 0: is_mapped, tlb_invalidate.
  output logic [spte_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int SH = spte_pkg::SECTION_SHIFT;
  localparam int AW = spte_pkg::ADDR_W;
  localparam int IW = spte_pkg::IDX_W;
  localparam int CW = spte_pkg::COUNT_W;
  localparam int EW = spte_pkg::ENTRY_W;

  // Input fields.
  logic [spte_pkg::OP_W-1:0] in_op;
  logic [AW-1:0]             in_addr;
  logic [AW-1:0]             in_bytes;
  logic [AW-1:0]             in_attr;
  logic [AW:0]               bytes_round;
  logic [CW-1:0]             in_count;
  logic                      in_fire;

  assign in_op       = in_tdata[spte_pkg::OP_W-1:0];
  assign in_addr     = in_tdata[spte_pkg::OP_W +: AW];
  assign in_bytes    = in_tdata[spte_pkg::OP_W + AW +: AW];
  assign in_attr     = in_tdata[spte_pkg::OP_W + 2*AW +: AW];
  assign bytes_round = {1'b0, in_bytes} + (AW+1)'((1 << SH) - 1);
  assign in_count    = bytes_round[AW:SH];

  // Registers.
  spte_pkg::state_t  state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              clear_r, clear_nxt;
  logic [EW-1:0]     attr_r, attr_nxt;
  spte_pkg::result_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  spte_pkg::result_t out_res_r, out_res_nxt;

  // Memory ports.
  logic [EW-1:0]     mem [spte_pkg::DEPTH];
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  logic [EW-1:0]     rd_data_r;

  logic              slot_free;

  assign in_tready = (state_r == spte_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(spte_pkg::OUT_TDATA_W - spte_pkg::OUT_FIELDS_W){1'b0}},
                       out_res_r.tlb_invalidate, out_res_r.is_mapped};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    clear_nxt     = clear_r;
    attr_nxt      = attr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = in_addr[AW-1:SH];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      spte_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(spte_pkg::DEPTH - 1)) begin
          state_nxt = spte_pkg::ST_IDLE;
        end
      end
      spte_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_nxt   = in_addr[AW-1:SH];
          cnt_nxt   = in_count;
          clear_nxt = (in_op == spte_pkg::OP_UNMAP);
          attr_nxt  = in_attr;
          res_nxt   = '0;
          case (in_op)
            spte_pkg::OP_MAP, spte_pkg::OP_UNMAP: begin
              if (in_bytes != '0) begin
                res_nxt.tlb_invalidate = 1'b1;
                state_nxt = spte_pkg::ST_WRITE;
              end else begin
                state_nxt = spte_pkg::ST_DONE;
              end
            end
            spte_pkg::OP_QUERY: begin
              mem_re    = 1'b1;
              state_nxt = spte_pkg::ST_READ;
            end
            default: begin
              state_nxt = spte_pkg::ST_DONE;
            end
          endcase
        end
      end
      spte_pkg::ST_WRITE: begin
        // Entry value is the section base ORed with the attributes, unmasked.
        mem_we    = 1'b1;
        mem_wdata = clear_r ? '0 : ({idx_r, {SH{1'b0}}} | attr_r);
        idx_nxt   = idx_r + IW'(1);
        cnt_nxt   = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = spte_pkg::ST_DONE;
        end
      end
      spte_pkg::ST_READ: begin
        res_nxt.is_mapped = (rd_data_r[EW-1:SH] == idx_r);
        state_nxt         = spte_pkg::ST_DONE;
      end
      spte_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = spte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spte_pkg::ST_CLEAR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clear_r   <= clear_nxt;
    attr_r    <= attr_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  a_query_reads : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == spte_pkg::OP_QUERY) |=> state_r == spte_pkg::ST_READ)
    else $error("query transfer did not move to the read cycle");

  a_write_states : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == spte_pkg::ST_CLEAR) || (state_r == spte_pkg::ST_WRITE))
    else $error("table written outside the clearing pass or a region write");

  a_count_live : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spte_pkg::ST_WRITE |-> cnt_r != '0)
    else $error("region write running with no sections left");

  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == spte_pkg::ST_DONE)
    else $error("result loaded without finishing an item");
`endif

endmodule

`default_nettype wire

FILE: bench/section_table_checker.sv
// Checker for the section page table engine: shadow table, expected results and comparison.
module section_table_checker
  import spte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // Fields from bit 0: operation[1:0], address[31:0], region_bytes[31:0], attributes[31:0].
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: is_mapped, tlb_invalidate.
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int unsigned           mismatches,
  output int unsigned           awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] SECT_BYTES = ADDR_W'(1) << SECTION_SHIFT;
  localparam logic [ADDR_W-1:0] SECT_MASK  = ~(SECT_BYTES - ADDR_W'(1));

  logic [ENTRY_W-1:0] shadow_sections [DEPTH];
  result_t            expected_results [$];

  initial mismatches = 0;
  assign awaiting = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic result_t resolve_request(input logic [IN_TDATA_W-1:0] req);
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  bytes;
    logic [ADDR_W-1:0]  attr;
    logic [ADDR_W:0]    span;
    logic [COUNT_W-1:0] sections;
    logic [ADDR_W-1:0]  sect_addr;
    result_t            res;
    op    = req[OP_W-1:0];
    addr  = req[OP_W +: ADDR_W];
    bytes = req[OP_W + ADDR_W +: ADDR_W];
    attr  = req[OP_W + 2 * ADDR_W +: ADDR_W];
    res   = '0;
    case (op)
      OP_MAP, OP_UNMAP: begin
        if (bytes != '0) begin
          // Round up to whole sections; the widest size covers every entry exactly once.
          span     = {1'b0, bytes} + {1'b0, SECT_BYTES - ADDR_W'(1)};
          sections = COUNT_W'(span >> SECTION_SHIFT);
          for (int unsigned i = 0; i < sections; i++) begin
            sect_addr = (addr & SECT_MASK) + (ADDR_W'(i) << SECTION_SHIFT);
            shadow_sections[sect_addr >> SECTION_SHIFT] =
                (op == OP_UNMAP) ? '0 : (sect_addr | attr);
          end
          res.tlb_invalidate = 1'b1;
        end
      end
      OP_QUERY: begin
        res.is_mapped = ((shadow_sections[addr >> SECTION_SHIFT] & SECT_MASK)
                         == (addr & SECT_MASK));
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      foreach (shadow_sections[i]) shadow_sections[i] = '0;
      expected_results.delete();
    end else begin
      // The result of an older item is retired before a new item is predicted.
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_FIELDS_W-1:0];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result transfer %b with nothing expected", got));
        end else begin
          want = expected_results.pop_front();
          if (got.is_mapped !== want.is_mapped) begin
            report_mismatch($sformatf("is_mapped %b, expected %b",
                                      got.is_mapped, want.is_mapped));
          end
          if (got.tlb_invalidate !== want.tlb_invalidate) begin
            report_mismatch($sformatf("tlb_invalidate %b, expected %b",
                                      got.tlb_invalidate, want.tlb_invalidate));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(resolve_request(in_tdata));
      end
    end
  end

endmodule

FILE: bench/tb_section_page_table_engine.sv
// Testbench top for the section page table engine: clock, reset, stimulus and verdict.
module tb_section_page_table_engine;
  import spte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 1530;
  localparam int unsigned SEGMENT_ITEMS  = 102;
  // The slowest quiet stretch is the clearing pass or a full-table map plus a receiver
  // stall; the limit is several times that.
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // Fields from bit 0: operation[1:0], address[31:0], region_bytes[31:0], attributes[31:0].
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  // Fields from bit 0: is_mapped, tlb_invalidate.
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;
  logic [ADDR_W-1:0] hot_bases [16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  section_page_table_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  section_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall bursts while idling is enabled.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_request(
    input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
    input logic [ADDR_W-1:0] bytes, input logic [ADDR_W-1:0] attr);
    return IN_TDATA_W'({attr, bytes, addr, op});
  endfunction

  // Holds the request on the bus, after an optional gap, until its transfer.
  task automatic send_request(input logic [IN_TDATA_W-1:0] req);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_fields(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [ADDR_W-1:0] bytes, input logic [ADDR_W-1:0] attr);
    send_request(pack_request(op, addr, bytes, attr));
  endtask

  // Stops sending until every outstanding result has been returned.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic pick_address(output logic [ADDR_W-1:0] addr);
    case ($urandom_range(0, 3))
      0: addr = $urandom;
      1, 2: addr = hot_bases[$urandom_range(0, 15)] | ($urandom & 32'h000F_FFFF);
      default: begin
        // Narrow windows at the bottom and top of memory make entries collide.
        addr = {8'h00, 4'($urandom), 20'($urandom)};
        if ($urandom_range(0, 1) == 1) addr[31:24] = 8'hFF;
      end
    endcase
  endtask

  task automatic make_random_request(output logic [IN_TDATA_W-1:0] req);
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] bytes;
    logic [ADDR_W-1:0] attr;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 30)      op = OP_MAP;
    else if (r < 50) op = OP_UNMAP;
    else if (r < 95) op = OP_QUERY;
    else             op = OP_SPARE;
    pick_address(addr);
    r = $urandom_range(0, 99);
    if (r < 5)       bytes = '0;
    else if (r < 85) bytes = $urandom_range(1, 32'h0040_0000);
    else if (r < 97) bytes = ADDR_W'($urandom_range(1, 16)) << SECTION_SHIFT;
    else if (r < 99) bytes = $urandom_range(1, 32'h0400_0000);
    else             bytes = $urandom;
    if ($urandom_range(0, 3) == 0) attr = $urandom;
    else                           attr = $urandom & 32'h000F_FFFF;
    if (op == OP_MAP) hot_bases[$urandom_range(0, 15)] = addr & 32'hFFF0_0000;
    req = pack_request(op, addr, bytes, attr);
  endtask

  initial begin
    logic [IN_TDATA_W-1:0] req;
    foreach (hot_bases[i]) hot_bases[i] = ADDR_W'($urandom_range(0, 15)) << SECTION_SHIFT;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty entry at section zero reads as mapped; other empty sections do not.
    send_fields(OP_QUERY, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_fields(OP_QUERY, 32'h0012_3456, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Zero-size map and unmap change nothing.
    send_fields(OP_MAP,   32'h1230_0000, 32'h0000_0000, 32'h0000_0C02);
    send_fields(OP_UNMAP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_fields(OP_MAP,   32'h1234_5678, 32'h0000_0001, 32'h0000_0C02);
    send_fields(OP_QUERY, 32'h123F_FFFF, 32'h0000_0000, 32'h0000_0000);
    // A region that runs past the top of memory wraps into section zero.
    send_fields(OP_MAP,   32'hFFF0_0000, 32'h0010_0001, 32'h0000_0012);
    send_fields(OP_QUERY, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_fields(OP_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    // Attribute bits that land in the base field alter the stored base.
    send_fields(OP_MAP,   32'h0050_0000, 32'h0000_0001, 32'h00A0_0000);
    send_fields(OP_QUERY, 32'h0050_0000, 32'h0000_0000, 32'h0000_0000);
    send_fields(OP_UNMAP, 32'h1230_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_fields(OP_QUERY, 32'h1230_0000, 32'h0000_0000, 32'h0000_0000);
    // The largest size covers the whole table exactly once.
    send_fields(OP_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(OP_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_fields(OP_QUERY, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_fields(OP_UNMAP, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_fields(OP_MAP,   32'h8000_0000, 32'hFFF0_0001, 32'h0000_0000);
    send_fields(OP_QUERY, 32'h7654_3210, 32'h0000_0000, 32'h0000_0000);
    // Unused operation code leaves the table alone and returns zeros.
    send_fields(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(OP_QUERY, 32'hABCD_EF01, 32'h0000_0000, 32'h0000_0000);
    send_fields(OP_UNMAP, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    drain_results();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        // Most segments idle, some run flat out, and the final one never idles.
        idle_en = (n + SEGMENT_ITEMS < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
        if (n == (RANDOM_ITEMS / SEGMENT_ITEMS / 2) * SEGMENT_ITEMS) drain_results();
      end
      make_random_request(req);
      send_request(req);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
